@@ rtl/ld_pkg.sv @@
// ----------------------------------------------------------------------------
// ld_pkg
// Shared types, command codes and output widths for the edit distance block.
// ----------------------------------------------------------------------------
package ld_pkg;

    localparam int DEFAULT_MAX_PATTERN = 64;
    localparam int DEFAULT_MAX_TEXT    = 256;

    localparam int CMD_W    = 2;
    localparam int SYM_W    = 8;
    localparam int DIST_W   = 9;
    localparam int PCOUNT_W = 7;

    localparam int DIST_SAT   = (1 << DIST_W) - 1;
    localparam int PCOUNT_SAT = (1 << PCOUNT_W) - 1;

    localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd2;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic             clear;
        logic             pat_we;
        logic [SYM_W-1:0] pat_sym;
    } ld_ctrl_t;

endpackage

@@ rtl/ld_if.sv @@
// ----------------------------------------------------------------------------
// ld_if
// Valid/ready channels for command beats and report beats.
// ----------------------------------------------------------------------------
interface ld_req_if
    import ld_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output command, output symbol, input ready);
    modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface ld_rsp_if
    import ld_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DIST_W-1:0]   distance;
    logic [PCOUNT_W-1:0] pattern_count;
    logic                dropped;

    modport source (output valid, output distance, output pattern_count,
                    output dropped, input ready);
    modport sink   (input valid, input distance, input pattern_count,
                    input dropped, output ready);
endinterface

@@ rtl/ld_cell.sv @@
// ----------------------------------------------------------------------------
// ld_cell
// One pattern position: holds its pattern byte and its column entry, updates
// the entry as a text token passes and hands the token to the next cell.
// ----------------------------------------------------------------------------
module ld_cell
    import ld_pkg::*;
#(
    parameter int DW  = 9,
    parameter int PLW = 7,
    parameter int IDX = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ld_ctrl_t         ctrl,
    input  logic [PLW-1:0]   plen,
    input  logic             in_valid,
    input  logic [SYM_W-1:0] in_sym,
    input  logic [DW-1:0]    in_left,
    input  logic [DW-1:0]    in_diag,
    output logic             out_valid,
    output logic [SYM_W-1:0] out_sym,
    output logic [DW-1:0]    out_left,
    output logic [DW-1:0]    out_diag
);

    logic [SYM_W-1:0] pat_reg;
    logic [DW-1:0]    val_reg;
    logic [DW-1:0]    val_next;
    logic             out_valid_reg;
    logic [SYM_W-1:0] out_sym_reg;
    logic [DW-1:0]    out_left_reg;
    logic [DW-1:0]    out_diag_reg;
    logic             active;
    logic [DW-1:0]    min_a;
    logic [DW-1:0]    min_b;

    assign active = (32'(plen) >= IDX);
    assign min_a  = (in_left < val_reg) ? in_left : val_reg;
    assign min_b  = (min_a < in_diag) ? min_a : in_diag;

    always_comb
    begin
        if (!active)
        begin
            val_next = in_left;
        end
        else if (pat_reg == in_sym)
        begin
            val_next = in_diag;
        end
        else
        begin
            val_next = min_b + DW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pat_we && (32'(plen) == IDX - 1))
        begin
            pat_reg <= ctrl.pat_sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg       <= DW'(IDX);
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            val_reg       <= DW'(IDX);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid;
            if (in_valid)
            begin
                val_reg <= val_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            out_sym_reg  <= in_sym;
            out_left_reg <= val_next;
            out_diag_reg <= val_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sym   = out_sym_reg;
    assign out_left  = out_left_reg;
    assign out_diag  = out_diag_reg;

endmodule

@@ rtl/levenshtein_distance.sv @@
// ----------------------------------------------------------------------------
// levenshtein_distance
// Edit distance between a stored pattern and a streamed text, computed by a
// systolic row of pattern cells.
//
//   channel   dir   beat fields
//   request   in    command, symbol
//   result    out   distance, pattern_count, dropped
//
// pattern and text beats are taken one per cycle while no report waits; a text
// beat walks the cell row one cell per cycle, so text beats overlap freely
// a report waits until the row has drained and the result register is free,
// then the result register loads
// request.ready is low only while a report is waiting; a stalled result
// holds the report and nothing else
// reset puts the column at 0..MAX_PATTERN at once, no clearing pass
// ----------------------------------------------------------------------------
module levenshtein_distance
    import ld_pkg::*;
#(
    parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
    parameter int MAX_TEXT    = DEFAULT_MAX_TEXT
)
(
    input  logic     clk,
    input  logic     rst_n,
    ld_req_if.sink   request,
    ld_rsp_if.source result
);

    localparam int MAXV = (MAX_PATTERN > MAX_TEXT) ? MAX_PATTERN : MAX_TEXT;
    localparam int DW   = $clog2(MAXV + 1);
    localparam int PLW  = $clog2(MAX_PATTERN + 1);
    localparam int TW   = $clog2(MAX_TEXT + 1);

    logic [PLW-1:0]      pattern_len_reg;
    logic [TW-1:0]       text_len_reg;
    logic                drop_reg;
    logic                report_pending_reg;
    logic                entry_valid_reg;
    logic [SYM_W-1:0]    entry_sym_reg;
    logic [DW-1:0]       entry_left_reg;
    logic [DW-1:0]       entry_diag_reg;
    logic                out_valid_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic [PCOUNT_W-1:0] out_pcount_reg;
    logic                out_drop_reg;

    logic                accept;
    logic                pat_ok;
    logic                text_ok;
    logic                chain_idle;
    logic                emit;
    logic [DW-1:0]       final_val;
    ld_ctrl_t            ctrl;

    logic [MAX_PATTERN:0] tok_valid;
    logic [SYM_W-1:0]     tok_sym  [MAX_PATTERN+1];
    logic [DW-1:0]        tok_left [MAX_PATTERN+1];
    logic [DW-1:0]        tok_diag [MAX_PATTERN+1];

    assign accept  = request.valid && request.ready;
    assign pat_ok  = (text_len_reg == '0) && (32'(pattern_len_reg) < MAX_PATTERN);
    assign text_ok = (32'(text_len_reg) < MAX_TEXT);

    assign chain_idle = (tok_valid == '0);
    assign emit       = report_pending_reg && chain_idle && (!out_valid_reg || result.ready);

    assign ctrl.clear   = emit;
    assign ctrl.pat_we  = accept && (request.command == CMD_PATTERN) && pat_ok;
    assign ctrl.pat_sym = request.symbol;

    assign tok_valid[0] = entry_valid_reg;
    assign tok_sym[0]   = entry_sym_reg;
    assign tok_left[0]  = entry_left_reg;
    assign tok_diag[0]  = entry_diag_reg;

    for (genvar i = 1; i <= MAX_PATTERN; i++)
    begin : g_cell
        ld_cell #(
            .DW  (DW),
            .PLW (PLW),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .plen      (pattern_len_reg),
            .in_valid  (tok_valid[i-1]),
            .in_sym    (tok_sym[i-1]),
            .in_left   (tok_left[i-1]),
            .in_diag   (tok_diag[i-1]),
            .out_valid (tok_valid[i]),
            .out_sym   (tok_sym[i]),
            .out_left  (tok_left[i]),
            .out_diag  (tok_diag[i])
        );
    end

    // with no text yet the last column entry is the pattern length
    assign final_val = (text_len_reg == '0) ? DW'(pattern_len_reg) : tok_left[MAX_PATTERN];

    // the last cell's register is reached through its out_left only after a
    // token has passed; inactive cells copy the boundary value along
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg    <= '0;
            text_len_reg       <= '0;
            drop_reg           <= 1'b0;
            report_pending_reg <= 1'b0;
            entry_valid_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= accept && (request.command == CMD_TEXT) && text_ok;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                report_pending_reg <= 1'b0;
                pattern_len_reg    <= '0;
                text_len_reg       <= '0;
                drop_reg           <= 1'b0;
            end
            else if (accept)
            begin
                case (request.command)
                    CMD_PATTERN:
                    begin
                        if (pat_ok)
                        begin
                            pattern_len_reg <= pattern_len_reg + PLW'(1);
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                    CMD_TEXT:
                    begin
                        if (text_ok)
                        begin
                            text_len_reg <= text_len_reg + TW'(1);
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                    CMD_REPORT:
                    begin
                        report_pending_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (request.command == CMD_TEXT))
        begin
            entry_sym_reg  <= request.symbol;
            entry_left_reg <= DW'(text_len_reg) + DW'(1);
            entry_diag_reg <= DW'(text_len_reg);
        end
        if (emit)
        begin
            out_dist_reg   <= (32'(final_val) > DIST_SAT) ? DIST_W'(DIST_SAT)
                                                          : DIST_W'(final_val);
            out_pcount_reg <= (32'(pattern_len_reg) > PCOUNT_SAT) ? PCOUNT_W'(PCOUNT_SAT)
                                                                  : PCOUNT_W'(pattern_len_reg);
            out_drop_reg   <= drop_reg;
        end
    end

    assign request.ready        = !report_pending_reg;
    assign result.valid         = out_valid_reg;
    assign result.distance      = out_dist_reg;
    assign result.pattern_count = out_pcount_reg;
    assign result.dropped       = out_drop_reg;

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg && !report_pending_reg)
        else $error("report not loaded into result register");

    a_text_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (request.command == CMD_TEXT) && text_ok |=> entry_valid_reg)
        else $error("text beat did not enter the cell row");

    a_tokens_need_text: assert property (@(posedge clk) disable iff (!rst_n)
        !chain_idle |-> (text_len_reg != '0))
        else $error("token in flight with no text counted");

    a_pending_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        report_pending_reg && !chain_idle |=> report_pending_reg)
        else $error("report left before the row drained");

endmodule

@@ tb/sv/distance_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_checker
// Watches the command and report channels of the edit distance block. It keeps
// its own copy of the pattern, the text length and the score column, works out
// the report that each report command must give, and compares every report
// beat field by field with the oldest one outstanding.
// ----------------------------------------------------------------------------
module distance_checker
    import ld_pkg::*;
#(
    parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN,
    parameter int MAX_TEXT    = DEFAULT_MAX_TEXT
)
(
    input  logic clk,
    input  logic rst_n,
    ld_req_if    request,
    ld_rsp_if    result,
    output int   errors,
    output int   pending,
    output int   checked
);

    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [PCOUNT_W-1:0] pattern_count;
        logic                dropped;
    } report_t;

    report_t          expected_reports[$];
    logic [SYM_W-1:0] pattern_bytes [MAX_PATTERN];
    int unsigned      column [MAX_PATTERN+1];
    int unsigned      pattern_len;
    int unsigned      text_len;
    logic             drop_seen;
    int               fail_count   = 0;
    int               report_count = 0;

    function automatic void restart_strings();
        for (int i = 0; i <= MAX_PATTERN; i++)
            column[i] = i;
        pattern_len = 0;
        text_len    = 0;
        drop_seen   = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        int unsigned diag;
        int unsigned up;
        int unsigned score;
        int unsigned raw_distance;
        report_t     want;
        report_t     got;
        if (!rst_n)
        begin
            restart_strings();
        end
        else
        begin
            if (request.valid && request.ready)
            begin
                case (request.command)
                    CMD_PATTERN:
                    begin
                        if (text_len != 0 || pattern_len >= MAX_PATTERN)
                            drop_seen = 1'b1;
                        else
                        begin
                            pattern_bytes[pattern_len] = request.symbol;
                            pattern_len++;
                        end
                    end
                    CMD_TEXT:
                    begin
                        if (text_len >= MAX_TEXT)
                            drop_seen = 1'b1;
                        else
                        begin
                            // one new column over the whole pattern
                            diag      = column[0];
                            column[0] = text_len + 1;
                            for (int i = 1; i <= pattern_len; i++)
                            begin
                                up = column[i];
                                if (pattern_bytes[i-1] == request.symbol)
                                    score = diag;
                                else
                                begin
                                    score = column[i-1];
                                    if (up < score)
                                        score = up;
                                    if (diag < score)
                                        score = diag;
                                    score++;
                                end
                                diag      = up;
                                column[i] = score;
                            end
                            text_len++;
                        end
                    end
                    CMD_REPORT:
                    begin
                        raw_distance = column[pattern_len];
                        want.distance      = DIST_W'((raw_distance > DIST_SAT) ?
                                                     DIST_SAT : raw_distance);
                        want.pattern_count = PCOUNT_W'((pattern_len > PCOUNT_SAT) ?
                                                       PCOUNT_SAT : pattern_len);
                        want.dropped       = drop_seen;
                        expected_reports   = {expected_reports, want};
                        restart_strings();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (result.valid && result.ready)
            begin
                got.distance      = result.distance;
                got.pattern_count = result.pattern_count;
                got.dropped       = result.dropped;
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: report beat with none outstanding: distance %0d count %0d",
                             $time, got.distance, got.pattern_count);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.distance !== want.distance)
                    begin
                        $display("%0t: report %0d distance expected %0d, got %0d",
                                 $time, report_count, want.distance, got.distance);
                        fail_count++;
                    end
                    if (got.pattern_count !== want.pattern_count)
                    begin
                        $display("%0t: report %0d pattern_count expected %0d, got %0d",
                                 $time, report_count, want.pattern_count, got.pattern_count);
                        fail_count++;
                    end
                    if (got.dropped !== want.dropped)
                    begin
                        $display("%0t: report %0d dropped expected %0b, got %0b",
                                 $time, report_count, want.dropped, got.dropped);
                        fail_count++;
                    end
                    report_count++;
                end
            end
        end
        errors  <= fail_count;
        pending <= expected_reports.size();
        checked <= report_count;
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pattern, text and report beats into the edit distance block: a short
// directed run over empty strings, byte extremes, late pattern bytes and the
// unused command, then random jobs over small alphabets with overflow cases
// and noise. The receiver stalls on its own pattern and once for a long
// stretch. The checker beside the block predicts and compares the reports.
// ----------------------------------------------------------------------------
module testbench
    import ld_pkg::*;
;

    localparam int               MAX_PATTERN = DEFAULT_MAX_PATTERN;
    localparam int               MAX_TEXT    = DEFAULT_MAX_TEXT;
    localparam int               BEAT_TARGET = 1950;
    localparam int               HOLD_CYCLES = 400;
    localparam int               CYCLE_LIMIT = 1500000;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    typedef enum {RX_FREE, RX_COIN, RX_SLOW} rx_mode_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ld_req_if req_ch();
    ld_rsp_if rsp_ch();

    int               errors;
    int               pending;
    int               checked;
    int               beats_sent  = 0;
    int               burst_left  = 0;
    int               cycle_count = 0;
    bit               long_hold   = 1'b0;
    logic [SYM_W-1:0] letters [4];

    levenshtein_distance #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (rsp_ch)
    );

    distance_checker #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (rsp_ch),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // offers one beat and returns at the edge that takes it, valid left high
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.symbol  <= sym;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (cmd != CMD_UNUSED)
            beats_sent++;
    endtask

    task automatic drain_reports();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol();
        if ($urandom_range(0, 7) == 0)
            return SYM_W'($urandom_range(0, 255));
        return letters[$urandom_range(0, 3)];
    endfunction

    // one pattern, one text and a report; noisy jobs slip in late pattern
    // bytes and unused commands between text beats
    task automatic run_job(input int pat_n, input int txt_n, input bit noisy);
        for (int k = 0; k < 4; k++)
            letters[k] = SYM_W'($urandom_range(0, 255));
        for (int i = 0; i < pat_n; i++)
            send_beat(CMD_PATTERN, pick_symbol());
        for (int i = 0; i < txt_n; i++)
        begin
            send_beat(CMD_TEXT, pick_symbol());
            if (noisy && $urandom_range(0, 9) == 0)
                send_beat($urandom_range(0, 1) ? CMD_PATTERN : CMD_UNUSED,
                          SYM_W'($urandom_range(0, 255)));
        end
        send_beat(CMD_REPORT, SYM_W'($urandom_range(0, 255)));
    endtask

    initial
    begin : receiver
        rx_mode_e rx_mode;
        int       seg_left;
        rx_mode      = RX_FREE;
        seg_left     = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    rx_mode  = rx_mode_e'($urandom_range(0, 2));
                    seg_left = $urandom_range(1, 60);
                end
                seg_left--;
                case (rx_mode)
                    RX_FREE: rsp_ch.ready <= 1'b1;
                    RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int job;
        int sel;
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_REPORT;
        req_ch.symbol  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // both strings empty
        send_beat(CMD_REPORT, 8'hFF);
        // pattern only, byte extremes
        send_beat(CMD_PATTERN, 8'h00);
        send_beat(CMD_PATTERN, 8'hFF);
        send_beat(CMD_REPORT, 8'h00);
        // text only
        send_beat(CMD_TEXT, 8'hFF);
        send_beat(CMD_TEXT, 8'h00);
        send_beat(CMD_TEXT, 8'h5A);
        send_beat(CMD_REPORT, 8'hA5);
        // swapped bytes
        send_beat(CMD_PATTERN, 8'h00);
        send_beat(CMD_PATTERN, 8'hFF);
        send_beat(CMD_TEXT, 8'hFF);
        send_beat(CMD_TEXT, 8'h00);
        send_beat(CMD_REPORT, 8'h00);
        // pattern byte after text is dropped, unused command does nothing
        send_beat(CMD_PATTERN, 8'hA5);
        send_beat(CMD_TEXT, 8'hA5);
        send_beat(CMD_PATTERN, 8'h3C);
        send_beat(CMD_UNUSED, 8'hFF);
        send_beat(CMD_REPORT, 8'hFF);
        send_beat(CMD_UNUSED, 8'h00);
        send_beat(CMD_PATTERN, 8'h11);
        send_beat(CMD_TEXT, 8'h11);
        send_beat(CMD_TEXT, 8'h12);
        send_beat(CMD_REPORT, 8'h00);

        job = 0;
        while (beats_sent < BEAT_TARGET)
        begin
            sel = $urandom_range(0, 19);
            if (job == 0)
                run_job(MAX_PATTERN + 3, 5, 1'b0);
            else if (job == 1)
                run_job(4, MAX_TEXT + 2, 1'b0);
            else if (job == 20)
            begin
                // result side blocked while reports keep coming
                long_hold = 1'b1;
                repeat (6) run_job($urandom_range(0, 6), $urandom_range(0, 6), 1'b0);
                drain_reports();
            end
            else if (sel == 0)
                run_job($urandom_range(48, MAX_PATTERN + 2), $urandom_range(0, 40), 1'b1);
            else if (sel == 1)
            begin
                repeat ($urandom_range(1, 12))
                    send_beat(CMD_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
                send_beat(CMD_REPORT, SYM_W'($urandom_range(0, 255)));
            end
            else
                run_job($urandom_range(0, 12), $urandom_range(0, 16), sel < 5);
            job++;
        end

        drain_reports();
        repeat (MAX_PATTERN + 8) @(posedge clk);
        $display("sent %0d command beats in %0d random jobs, %0d reports checked",
                 beats_sent, job, checked);
        $display("covered empty strings, both overflows, late pattern bytes, noise, stalls");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
